// ===== hdl/lrpf_pkg.sv =====
// Shared types and constants for the page-organized line rasterizer framebuffer.
// Used by the front, queue, back and top level modules; depends on nothing.
`default_nettype none

package lrpf_pkg;

  localparam int SCREEN_WIDTH  = 84;
  localparam int SCREEN_HEIGHT = 48;
  localparam int STORE_PAGES   = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_DEPTH   = SCREEN_WIDTH * STORE_PAGES;
  localparam int ADDR_W        = $clog2(STORE_DEPTH);

  // Bresenham error term: holds values from minus one full run up to one less than a run.
  localparam int ERR_W = 10;

  // Entries of the command queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    REQ_LINE  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // One classified request, ready for the back end to carry out.
  typedef struct packed {
    req_t                   kind;
    logic                   on;
    logic                   steep;
    logic                   step_neg;
    logic signed [7:0]      maj_start;
    logic signed [7:0]      mnr_start;
    logic [7:0]             run;
    logic [7:0]             rise;
    logic                   rd_ok;
    logic [ADDR_W-1:0]      rd_addr;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/lrpf_front.sv =====
// Front end: holds one accepted request word and classifies it into a command.
// Depends on lrpf_pkg; feeds lrpf_queue.
`default_nettype none

module lrpf_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [7:0]  x_start,
  input  wire logic signed [7:0]  y_start,
  input  wire logic signed [7:0]  x_end,
  input  wire logic signed [7:0]  y_end,
  input  wire logic               pixel_on,
  input  wire logic [8:0]         byte_index,
  input  wire logic               init_busy,
  input  wire logic               q_full,
  output logic                    push,
  output lrpf_pkg::cmd_t          cmd
);
  import lrpf_pkg::*;

  logic              held;
  logic [1:0]        h_type;
  logic signed [7:0] h_xs, h_ys, h_xe, h_ye;
  logic              h_on;
  logic [8:0]        h_idx;

  logic signed [8:0] dx, dy;
  logic [7:0]        adx, ady;
  logic              steep, swap;
  logic signed [7:0] a_maj, a_mnr, b_maj, b_mnr, s_mnr, e_mnr;
  logic              accept;

  assign push     = held && !q_full;
  assign in_stall = init_busy || (held && q_full);
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (accept) begin
      held <= 1'b1;
    end else if (push) begin
      held <= 1'b0;
    end
    if (accept) begin
      h_type <= req_type;
      h_xs   <= x_start;
      h_ys   <= y_start;
      h_xe   <= x_end;
      h_ye   <= y_end;
      h_on   <= pixel_on;
      h_idx  <= byte_index;
    end
  end

  // Line setup: pick the major axis, order the ends along it, and find the
  // direction of the minor axis; then fill in the command and the read range check.
  always_comb begin
    dx    = {h_xe[7], h_xe} - {h_xs[7], h_xs};
    dy    = {h_ye[7], h_ye} - {h_ys[7], h_ys};
    adx   = dx[8] ? 8'(-dx) : dx[7:0];
    ady   = dy[8] ? 8'(-dy) : dy[7:0];
    steep = ady > adx;
    a_maj = steep ? h_ys : h_xs;
    a_mnr = steep ? h_xs : h_ys;
    b_maj = steep ? h_ye : h_xe;
    b_mnr = steep ? h_xe : h_ye;
    swap  = a_maj > b_maj;
    s_mnr = swap ? b_mnr : a_mnr;
    e_mnr = swap ? a_mnr : b_mnr;

    cmd.kind      = req_t'(h_type);
    cmd.on        = h_on;
    cmd.steep     = steep;
    cmd.step_neg  = !(s_mnr < e_mnr);
    cmd.maj_start = swap ? b_maj : a_maj;
    cmd.mnr_start = s_mnr;
    cmd.run       = steep ? ady : adx;
    cmd.rise      = steep ? adx : ady;
    cmd.rd_ok     = 32'(h_idx) < STORE_DEPTH;
    cmd.rd_addr   = ADDR_W'(h_idx);
  end

endmodule

`default_nettype wire

// ===== hdl/lrpf_queue.sv =====
// Short command queue that decouples the front end from the back end.
// Depends on lrpf_pkg for the command type and depth.
`default_nettype none

module lrpf_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  lrpf_pkg::cmd_t   push_cmd,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output lrpf_pkg::cmd_t   head
);
  import lrpf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = count == CNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lrpf_back.sv =====
// Back end: framebuffer memory, Bresenham stepper with pixel read-modify-write,
// clear sweep, byte read and the result register. Depends on lrpf_pkg.
`default_nettype none

module lrpf_back (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  lrpf_pkg::cmd_t   q_head,
  output logic             pop,
  output logic             init_busy,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       read_byte,
  output logic [1:0]       done_type
);
  import lrpf_pkg::*;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LINE,
    ST_DRAIN,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } state_t;

  state_t                   state;
  cmd_t                     cur;
  logic [ADDR_W-1:0]        sweep;
  logic signed [7:0]        maj, mnr;
  logic [7:0]               cnt;
  logic signed [ERR_W-1:0]  err;
  logic [7:0]               res_byte;

  logic [7:0]               mem [STORE_DEPTH];
  logic [7:0]               rd_data;
  logic [ADDR_W-1:0]        ra, wa;
  logic [7:0]               wd;
  logic                     we;

  logic                     p1_valid;
  logic [ADDR_W-1:0]        p1_addr;
  logic [7:0]               p1_mask;
  logic                     fw_valid;
  logic [ADDR_W-1:0]        fw_addr;
  logic [7:0]               fw_data;

  logic signed [7:0]        px, py, mnr_next;
  logic                     in_screen;
  logic [ADDR_W-1:0]        pix_addr;
  logic signed [ERR_W-1:0]  err_sub;
  logic [7:0]               base, pix_wd;

  assign init_busy = state == ST_INIT;
  assign pop       = (state == ST_IDLE) && q_valid;

  // Pixel address, screen check, error update and minor step for the current step.
  always_comb begin
    px        = cur.steep ? mnr : maj;
    py        = cur.steep ? maj : mnr;
    in_screen = !px[7] && !py[7] && (px < 8'(SCREEN_WIDTH)) && (py < 8'(SCREEN_HEIGHT));
    pix_addr  = ADDR_W'(px[6:0]) + ADDR_W'(py[6:3]) * ADDR_W'(SCREEN_WIDTH);
    err_sub   = err - $signed({2'b00, cur.rise});
    mnr_next  = cur.step_neg ? mnr - 8'sd1 : mnr + 8'sd1;
  end

  // The byte written on the previous cycle has not reached the read data yet.
  always_comb begin
    base   = (fw_valid && (fw_addr == p1_addr)) ? fw_data : rd_data;
    pix_wd = cur.on ? (base | p1_mask) : (base & ~p1_mask);
    ra     = (state == ST_IDLE) ? q_head.rd_addr : pix_addr;
    if (state == ST_INIT || state == ST_CLEAR) begin
      we = 1'b1;
      wa = sweep;
      wd = 8'h00;
    end else begin
      we = p1_valid;
      wa = p1_addr;
      wd = pix_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      sweep     <= '0;
      out_valid <= 1'b0;
      p1_valid  <= 1'b0;
      fw_valid  <= 1'b0;
    end else begin
      p1_valid <= (state == ST_LINE) && in_screen;
      fw_valid <= p1_valid;
      // In ST_DONE the result register is refilled, or left as it is, below.
      if (out_valid && !out_stall && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          sweep <= sweep + ADDR_W'(1);
          if (sweep == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cur      <= q_head;
            maj      <= q_head.maj_start;
            mnr      <= q_head.mnr_start;
            cnt      <= q_head.run;
            err      <= $signed({2'b00, 1'b0, q_head.run[7:1]});
            sweep    <= '0;
            res_byte <= 8'h00;
            case (q_head.kind)
              REQ_LINE:  state <= ST_LINE;
              REQ_CLEAR: state <= ST_CLEAR;
              REQ_READ:  state <= ST_READ;
              default:   state <= ST_DONE;
            endcase
          end
        end
        ST_LINE: begin
          maj <= maj + 8'sd1;
          cnt <= cnt - 8'd1;
          if (err_sub < 0) begin
            mnr <= mnr_next;
            err <= err_sub + $signed({2'b00, cur.run});
          end else begin
            err <= err_sub;
          end
          if (cnt == 8'd0) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_CLEAR: begin
          sweep <= sweep + ADDR_W'(1);
          if (sweep == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_READ: begin
          res_byte <= cur.rd_ok ? rd_data : 8'h00;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            read_byte <= res_byte;
            done_type <= cur.kind;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
    p1_addr <= pix_addr;
    p1_mask <= 8'h01 << py[2:0];
    fw_addr <= p1_addr;
    fw_data <= pix_wd;
  end

`ifndef NO_ASSERTIONS
  a_pixel_follows_line: assert property (@(posedge clk) disable iff (rst)
    p1_valid |-> $past(state == ST_LINE))
    else $error("pixel write without a line step before it");

  a_no_write_clash: assert property (@(posedge clk) disable iff (rst)
    !(p1_valid && (state == ST_INIT || state == ST_CLEAR)))
    else $error("pixel write collides with clear sweep");

  a_err_nonneg: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LINE) |-> !err[ERR_W-1])
    else $error("Bresenham error term negative at step start");

  a_zero_unless_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && cur.kind != REQ_READ) |-> (res_byte == 8'h00))
    else $error("nonzero result byte for a request that is not a read");

  a_full_init_sweep: assert property (@(posedge clk) disable iff (rst)
    $fell(state == ST_INIT) |-> ($past(sweep) == ADDR_W'(STORE_DEPTH - 1)))
    else $error("reset clearing pass ended early");
`endif

endmodule

`default_nettype wire

// ===== hdl/line_rasterizer_page_framebuffer_top.sv =====
// Top level of the page-organized 1-bit-per-pixel framebuffer with line drawing.
// Depends on lrpf_pkg and instantiates lrpf_front, lrpf_queue and lrpf_back.
//
//   Channel  Direction  Handshake             Word
//   in       input      in_valid / in_stall   req_type, x_start, y_start, x_end,
//                                             y_end, pixel_on, byte_index
//   out      output     out_valid / out_stall read_byte, done_type
//
// A line makes run + 1 pixel steps, one per cycle, with a read-modify-write
// for each pixel on screen, where run is the span along its major axis (at
// most 255), and then passes through the drain state and the result register.
// A clear zeroes every store byte (504 at the default size), one byte per cycle.
// Every request gives exactly one result word.
// After reset a clearing pass zeroes all 504 store bytes; in_stall stays
// high until it ends. Stalls on out back up into the two-entry queue and the
// front holding register before in_stall rises.
`default_nettype none

module line_rasterizer_page_framebuffer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         req_type,
  input  wire logic signed [7:0]  x_start,
  input  wire logic signed [7:0]  y_start,
  input  wire logic signed [7:0]  x_end,
  input  wire logic signed [7:0]  y_end,
  input  wire logic               pixel_on,
  input  wire logic [8:0]         byte_index,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [7:0]              read_byte,
  output logic [1:0]              done_type
);
  import lrpf_pkg::*;

  cmd_t front_cmd, queue_head;
  logic push, q_full, q_valid, pop, init_busy;

  // The front classifies each word: line setup (major axis, end order, step
  // direction) and the read range check are settled before it is queued.
  lrpf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .x_start    (x_start),
    .y_start    (y_start),
    .x_end      (x_end),
    .y_end      (y_end),
    .pixel_on   (pixel_on),
    .byte_index (byte_index),
    .init_busy  (init_busy),
    .q_full     (q_full),
    .push       (push),
    .cmd        (front_cmd)
  );

  // The queue lets the front take new words while the back is busy drawing.
  lrpf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (front_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (queue_head)
  );

  // The back owns the store and runs one command at a time to completion.
  lrpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (queue_head),
    .pop       (pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .read_byte (read_byte),
    .done_type (done_type)
  );

endmodule

`default_nettype wire
